[src/fprx_pkg.sv]
// shared constants, codes and the crc helper for the framed packet receiver
package fprx_pkg;

  // stream and register widths; data widths padded to whole bytes
  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // default buffer depth
  localparam int DEFAULT_BUFFER_DEPTH = 256;

  // input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result kinds
  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_LEN_MIS   = 3'd4;
  localparam logic [2:0] ST_CRC_ERR   = 3'd5;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TYPE    = 2'd2;

  // register reset values
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd80;
  localparam logic [7:0]  TYPE_RESET    = 8'd4;

  // frame layout
  localparam logic [7:0]  START_BYTE    = 8'd2;
  localparam logic [7:0]  PAYLOAD_FIRST = 8'd2;
  localparam logic [7:0]  SHORT_LIMIT   = 8'd3;
  localparam logic [8:0]  LEN_OVERHEAD  = 9'd5;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // crc-16/xmodem over one byte, msb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/framed_packet_receiver_crc16_core.sv]
// framed packet receiver: capture buffer, running crc-16 check and buffer reads
// A result passes through a pending stage and then the output register that drives m_tvalid.
// Throughput: one beat per cycle unless the output stalls; the frame buffer is kept as
// two copies with two registered read ports each, for a 32-bit read or both crc bytes.
// Reset clears control state, counters and registers; the buffer is not cleared and
// holds unknown data until written.
module framed_packet_receiver_crc16_core #(
  parameter int BUFFER_DEPTH = fprx_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave side
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [fprx_pkg::IN_DATA_W-1:0]     s_tdata,  // rx_byte, read_index, read_wide
  input  logic [fprx_pkg::IN_USER_W-1:0]     s_tuser,  // opcode
  // master side
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [fprx_pkg::OUT_DATA_W-1:0]    m_tdata,  // frame_status, byte_count, read_data
  output logic                               m_tuser,  // result_kind
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fprx_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fprx_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fprx_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int NCOPY = 2;
  localparam int NREAD = 2 * NCOPY;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(BUFFER_DEPTH);
  localparam logic [AW-1:0] ADDR0 = '0;
  localparam logic [AW-1:0] ADDR1 = AW'(1);
  localparam logic [AW-1:0] ADDR2 = AW'(2);

  // byte position to buffer address, worked out at elaboration
  typedef logic [AW-1:0] mod_lut_t [256];

  function automatic mod_lut_t build_mod_lut();
    mod_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = AW'(i % BUFFER_DEPTH);
    end
    return lut;
  endfunction

  localparam mod_lut_t MOD_LUT = build_mod_lut();

  // address plus a small offset, wrapped once at the depth
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [1:0] offs);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(offs);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // configuration registers
  logic [15:0] timeout_ms;
  logic [7:0]  max_packet_length;
  logic [7:0]  expected_type;

  // capture state
  logic        capturing;
  logic [7:0]  captured_count;
  logic [15:0] running_crc;
  logic [15:0] elapsed_ticks;
  logic [7:0]  buf0, buf1, buf2;

  // beat fields
  logic [1:0]  opcode;
  logic [7:0]  rx_byte;
  logic [7:0]  read_index;
  logic        read_wide;

  // accept stage signals
  logic          accept;
  logic          is_byte;
  logic [AW-1:0] wr_addr;
  logic [7:0]    buf0_next, buf1_next, buf2_next;
  logic [7:0]    count_next;
  logic [15:0]   crc_next;
  logic [15:0]   ticks_next;
  logic          in_payload;
  logic          close;
  logic          has_result;
  logic [7:0]    count_close;
  logic [2:0]    status_pre;
  logic [AW-1:0] len_addr, idx_addr;
  logic [AW-1:0] crc_hi_addr, crc_lo_addr;
  logic [AW-1:0] raddr [NREAD];
  logic [7:0]    rdata [NREAD];

  // pending result stage
  logic        pend_valid;
  logic        pend_kind;
  logic [2:0]  pend_status;
  logic [7:0]  pend_count;
  logic [15:0] pend_crc;
  logic        pend_wide;
  logic        pend_fwd_hi, pend_fwd_lo;
  logic [7:0]  pend_fwd_byte;
  logic        pend_move;

  // formed result
  logic [7:0]  crc_hi, crc_lo;
  logic [2:0]  frame_status;
  logic [31:0] read_data;

  // output register
  logic        out_valid;
  logic        out_kind;
  logic [2:0]  out_status;
  logic [7:0]  out_count;
  logic [31:0] out_data;

  assign opcode     = s_tuser;
  assign rx_byte    = s_tdata[7:0];
  assign read_index = s_tdata[15:8];
  assign read_wide  = s_tdata[16];

  // flow control: pending stage drains into the output register
  assign pend_move = pend_valid && (!out_valid || m_tready);
  assign s_tready  = !pend_valid || pend_move;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // byte write and shadow copies of the first three buffer entries
  assign is_byte   = (opcode == OP_BYTE) && capturing;
  assign wr_addr   = MOD_LUT[captured_count];
  assign buf0_next = (is_byte && wr_addr == ADDR0) ? rx_byte : buf0;
  assign buf1_next = (is_byte && wr_addr == ADDR1) ? rx_byte : buf1;
  assign buf2_next = (is_byte && wr_addr == ADDR2) ? rx_byte : buf2;

  // count, crc and tick updates
  assign count_next = captured_count + 8'd1;
  assign in_payload = (captured_count >= PAYLOAD_FIRST) &&
                      ({1'b0, captured_count} < {1'b0, PAYLOAD_FIRST} + {1'b0, buf1_next});
  assign crc_next   = in_payload ? crc16_byte(running_crc, rx_byte) : running_crc;
  assign ticks_next = (elapsed_ticks == TICK_MAX) ? elapsed_ticks : elapsed_ticks + 16'd1;

  // close decision per opcode
  always_comb begin
    close       = 1'b0;
    count_close = captured_count;
    unique case (opcode)
      OP_START: begin
        close       = (timeout_ms == 16'd0);
        count_close = 8'd0;
      end
      OP_BYTE: begin
        count_close = count_next;
        close = capturing &&
                ((count_next >= max_packet_length) ||
                 ((count_next >= 8'd2) && (buf0_next == START_BYTE) &&
                  ({1'b0, count_next} >= {1'b0, buf1_next} + LEN_OVERHEAD)));
      end
      OP_TICK: begin
        close = capturing && (ticks_next >= timeout_ms);
      end
      default: begin
        close = 1'b0;
      end
    endcase
  end

  assign has_result = close || (opcode == OP_READ);

  // frame checks before the crc compare
  always_comb begin
    priority if (count_close < SHORT_LIMIT) begin
      status_pre = ST_SHORT;
    end else if (buf0_next != START_BYTE) begin
      status_pre = ST_BAD_START;
    end else if (buf2_next != expected_type) begin
      status_pre = ST_BAD_TYPE;
    end else if ({1'b0, count_close} != {1'b0, buf1_next} + LEN_OVERHEAD) begin
      status_pre = ST_LEN_MIS;
    end else begin
      status_pre = ST_OK;
    end
  end

  // read addresses: crc bytes on close, four consecutive bytes on a read
  assign len_addr    = MOD_LUT[buf1_next];
  assign idx_addr    = MOD_LUT[read_index];
  assign crc_hi_addr = wrap_add(len_addr, 2'd2);
  assign crc_lo_addr = wrap_add(len_addr, 2'd3);

  always_comb begin
    for (int k = 0; k < NREAD; k++) begin
      raddr[k] = wrap_add(idx_addr, 2'(k));
    end
    if (opcode != OP_READ) begin
      raddr[0] = crc_hi_addr;
      raddr[1] = crc_lo_addr;
    end
  end

  // buffer copies: same write, two read ports each
  for (genvar g = 0; g < NCOPY; g++) begin : g_copy
    logic [7:0] mem [BUFFER_DEPTH];

    always_ff @(posedge clk) begin
      if (accept && is_byte) begin
        mem[wr_addr] <= rx_byte;
      end
      if (accept && has_result) begin
        rdata[2*g]   <= mem[raddr[2*g]];
        rdata[2*g+1] <= mem[raddr[2*g+1]];
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms        <= TIMEOUT_RESET;
      max_packet_length <= MAX_LEN_RESET;
      expected_type     <= TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_ms        <= cfg_data;
        REG_MAX_LEN: max_packet_length <= cfg_data[7:0];
        REG_TYPE:    expected_type     <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  // capture state update
  always_ff @(posedge clk) begin
    if (rst) begin
      capturing      <= 1'b0;
      captured_count <= 8'd0;
      running_crc    <= 16'd0;
      elapsed_ticks  <= 16'd0;
    end else if (accept) begin
      unique case (opcode)
        OP_START: begin
          capturing      <= !close;
          captured_count <= 8'd0;
          running_crc    <= 16'd0;
          elapsed_ticks  <= 16'd0;
        end
        OP_BYTE: begin
          if (capturing) begin
            capturing      <= !close;
            captured_count <= count_next;
            running_crc    <= crc_next;
          end
        end
        OP_TICK: begin
          if (capturing) begin
            capturing     <= !close;
            elapsed_ticks <= ticks_next;
          end
        end
        default: ;
      endcase
    end
  end

  // shadow entries follow buffer writes
  always_ff @(posedge clk) begin
    if (accept) begin
      buf0 <= buf0_next;
      buf1 <= buf1_next;
      buf2 <= buf2_next;
    end
  end

  // pending result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= has_result;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      pend_kind     <= (opcode == OP_READ) ? KIND_READ : KIND_CAPTURE;
      pend_status   <= status_pre;
      pend_count    <= (opcode == OP_READ) ? captured_count : count_close;
      pend_crc      <= (opcode == OP_BYTE) ? crc_next : running_crc;
      pend_wide     <= read_wide;
      pend_fwd_hi   <= is_byte && (wr_addr == crc_hi_addr);
      pend_fwd_lo   <= is_byte && (wr_addr == crc_lo_addr);
      pend_fwd_byte <= rx_byte;
    end
  end

  // crc compare and read data assembly
  assign crc_hi = pend_fwd_hi ? pend_fwd_byte : rdata[0];
  assign crc_lo = pend_fwd_lo ? pend_fwd_byte : rdata[1];

  always_comb begin
    frame_status = ST_OK;
    read_data    = 32'd0;
    unique case (pend_kind)
      KIND_CAPTURE: begin
        frame_status = (pend_status == ST_OK && {crc_hi, crc_lo} != pend_crc) ?
                       ST_CRC_ERR : pend_status;
      end
      KIND_READ: begin
        read_data = pend_wide ? {rdata[0], rdata[1], rdata[2], rdata[3]}
                              : {16'd0, rdata[0], rdata[1]};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_kind   <= pend_kind;
      out_status <= frame_status;
      out_count  <= pend_count;
      out_data   <= read_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {5'd0, out_data, out_count, out_status};

endmodule
